### hw/rtl/ebml_hp_pkg.sv
package ebml_hp_pkg;

  // field widths of the element header result
  localparam int unsigned IdW      = 32;
  localparam int unsigned IdLenW   = 3;
  localparam int unsigned SizeW    = 56;
  localparam int unsigned SizeLenW = 4;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ID    = 2'd1,
    ST_BAD_SIZE  = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  // parser phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_ID_REST  = 4'b0010,
    PH_SZ_FIRST = 4'b0100,
    PH_SZ_REST  = 4'b1000
  } phase_t;

  // one parsed header or error
  typedef struct packed {
    status_t               status;
    logic [IdW-1:0]        element_id;
    logic [IdLenW-1:0]     id_length;
    logic [SizeW-1:0]      element_size;
    logic [SizeLenW-1:0]   size_length;
  } result_t;

  // count of leading zero bits in a byte, 8 for zero
  function automatic logic [3:0] lead_zeros8(input logic [7:0] b);
    logic [3:0] n;
    logic       found;
    n     = 4'd0;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found && !b[i]) begin
        n = n + 4'd1;
      end else begin
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

### hw/rtl/ebml_hp_in_if.sv
interface ebml_hp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

### hw/rtl/ebml_hp_out_if.sv
interface ebml_hp_out_if;
  import ebml_hp_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [IdW-1:0]      element_id;
  logic [IdLenW-1:0]   id_length;
  logic [SizeW-1:0]    element_size;
  logic [SizeLenW-1:0] size_length;

  modport source (output valid, output status, output element_id, output id_length,
                  output element_size, output size_length, input ready);
  modport sink   (input valid, input status, input element_id, input id_length,
                  input element_size, input size_length, output ready);
endinterface

### hw/rtl/ebml_hp_core.sv
module ebml_hp_core #(
  parameter int unsigned MAX_ID_BYTES   = 4,
  parameter int unsigned MAX_SIZE_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_stream,
  output logic                 res_valid,
  output ebml_hp_pkg::result_t res
);
  import ebml_hp_pkg::*;

  localparam logic [3:0] MaxIdLen   = 4'(MAX_ID_BYTES);
  localparam logic [3:0] MaxSizeLen = 4'(MAX_SIZE_BYTES);

  phase_t              phase_r, phase_nxt;
  logic [3:0]          bytes_left_r, bytes_left_nxt;
  logic [IdW-1:0]      id_accum_r, id_accum_nxt;
  logic [SizeW-1:0]    size_accum_r, size_accum_nxt;
  logic [IdLenW-1:0]   id_len_r, id_len_nxt;
  logic [SizeLenW-1:0] size_len_r, size_len_nxt;

  logic [3:0]          len;
  logic [3:0]          left;
  logic [IdW-1:0]      id_shift;
  logic [SizeW-1:0]    size_shift;

  assign len        = lead_zeros8(data_byte) + 4'd1;
  assign id_shift   = {id_accum_r[IdW-9:0], data_byte};
  assign size_shift = {size_accum_r[SizeW-9:0], data_byte};

  // next state and result for the byte on the input
  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    id_accum_nxt   = id_accum_r;
    size_accum_nxt = size_accum_r;
    id_len_nxt     = id_len_r;
    size_len_nxt   = size_len_r;
    res_valid      = 1'b0;
    res            = '0;
    left           = 4'd0;

    case (phase_r)
      PH_IDLE: begin
        if (data_byte[7:4] == 4'd0 || len > MaxIdLen) begin
          res_valid  = 1'b1;
          res.status = ST_BAD_ID;
        end else begin
          left           = len - 4'd1;
          id_accum_nxt   = {{(IdW-8){1'b0}}, data_byte};
          id_len_nxt     = len[IdLenW-1:0];
          bytes_left_nxt = left;
          phase_nxt      = (left != 4'd0) ? PH_ID_REST : PH_SZ_FIRST;
          if (end_of_stream) begin
            res_valid  = 1'b1;
            res.status = ST_TRUNCATED;
            if (left == 4'd0) begin
              res.element_id = {{(IdW-8){1'b0}}, data_byte};
              res.id_length  = len[IdLenW-1:0];
            end
          end
        end
      end
      PH_ID_REST: begin
        left           = (bytes_left_r != 4'd0) ? bytes_left_r - 4'd1 : 4'd0;
        id_accum_nxt   = id_shift;
        bytes_left_nxt = left;
        if (left == 4'd0) begin
          phase_nxt = PH_SZ_FIRST;
        end
        if (end_of_stream) begin
          res_valid  = 1'b1;
          res.status = ST_TRUNCATED;
          if (left == 4'd0) begin
            res.element_id = id_shift;
            res.id_length  = id_len_r;
          end
        end
      end
      PH_SZ_FIRST: begin
        res.element_id = id_accum_r;
        res.id_length  = id_len_r;
        if (data_byte == 8'd0 || len > MaxSizeLen) begin
          res_valid  = 1'b1;
          res.status = ST_BAD_SIZE;
        end else begin
          left           = len - 4'd1;
          size_accum_nxt = {{(SizeW-8){1'b0}}, data_byte & (8'hFF >> len)};
          size_len_nxt   = len;
          bytes_left_nxt = left;
          phase_nxt      = PH_SZ_REST;
          if (left == 4'd0) begin
            // one-byte size finishes the header
            res_valid        = 1'b1;
            res.status       = ST_OK;
            res.element_size = {{(SizeW-8){1'b0}}, data_byte & (8'hFF >> len)};
            res.size_length  = len;
          end else if (end_of_stream) begin
            res_valid  = 1'b1;
            res.status = ST_TRUNCATED;
          end
        end
      end
      PH_SZ_REST: begin
        left           = (bytes_left_r != 4'd0) ? bytes_left_r - 4'd1 : 4'd0;
        size_accum_nxt = size_shift;
        bytes_left_nxt = left;
        res.element_id = id_accum_r;
        res.id_length  = id_len_r;
        if (left == 4'd0) begin
          res_valid        = 1'b1;
          res.status       = ST_OK;
          res.element_size = size_shift;
          res.size_length  = size_len_r;
        end else if (end_of_stream) begin
          res_valid  = 1'b1;
          res.status = ST_TRUNCATED;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // every result returns the parser to idle
    if (res_valid) begin
      phase_nxt      = PH_IDLE;
      bytes_left_nxt = 4'd0;
      id_accum_nxt   = '0;
      size_accum_nxt = '0;
      id_len_nxt     = '0;
      size_len_nxt   = '0;
    end
  end

  // parser state, advanced on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bytes_left_r <= 4'd0;
      id_accum_r   <= '0;
      size_accum_r <= '0;
      id_len_r     <= '0;
      size_len_r   <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      id_accum_r   <= id_accum_nxt;
      size_accum_r <= size_accum_nxt;
      id_len_r     <= id_len_nxt;
      size_len_r   <= size_len_nxt;
    end
  end

endmodule

### hw/rtl/ebml_element_header_parser.sv
// channel  | dir | payload                                              | handshake
// in_bus   | in  | data_byte, end_of_stream                             | valid/ready
// out_bus  | out | status, element_id, id_length, element_size,        | valid/ready
//          |     | size_length                                          |
//
// one byte per cycle while input is ready; the result for the byte that completes
// a header or hits an error is registered in the output register or the skid entry.
// rst_n is synchronous, active low, and returns the parser to idle with no result held.
// a two-entry result buffer (output register plus skid) keeps input ready while one
// result waits; input stalls only when both entries are full.
module ebml_element_header_parser #(
  parameter int unsigned MAX_ID_BYTES   = 4,
  parameter int unsigned MAX_SIZE_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  ebml_hp_in_if.sink    in_bus,
  ebml_hp_out_if.source out_bus
);
  import ebml_hp_pkg::*;

  logic    in_fire;
  logic    out_fire;
  logic    res_valid;
  result_t res;

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    push;

  assign in_bus.ready = !skid_valid_r;
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign out_fire     = out_valid_r && out_bus.ready;
  assign push         = in_fire && res_valid;

  ebml_hp_core #(
    .MAX_ID_BYTES  (MAX_ID_BYTES),
    .MAX_SIZE_BYTES(MAX_SIZE_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_fire),
    .data_byte    (in_bus.data_byte),
    .end_of_stream(in_bus.end_of_stream),
    .res_valid    (res_valid),
    .res          (res)
  );

  // result buffer: output register with skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_fire) begin
      out_valid_nxt = push;
      if (push) begin
        out_nxt = res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // result port
  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = out_r.status;
  assign out_bus.element_id   = out_r.element_id;
  assign out_bus.id_length    = out_r.id_length;
  assign out_bus.element_size = out_r.element_size;
  assign out_bus.size_length  = out_r.size_length;

endmodule

### test/ebml_hp_checker.sv
`timescale 1ns / 100ps

module ebml_hp_checker #(
  parameter int unsigned IdMaxBytes   = 4,
  parameter int unsigned SizeMaxBytes = 8
) (
  input  logic   clk,
  input  logic   rst_n,
  ebml_hp_in_if  in_mon,
  ebml_hp_out_if out_mon,
  output int     fail_count,
  output int     headers_pending
);
  import ebml_hp_pkg::*;

  // header parse state tracked alongside the block
  phase_t              hdr_phase;
  logic [3:0]          left_cnt;
  logic [IdW-1:0]      id_acc;
  logic [SizeW-1:0]    size_acc;
  logic [IdLenW-1:0]   id_len;
  logic [SizeLenW-1:0] size_len;

  // headers and errors still owed by the block, oldest first
  result_t expected_headers [$];

  // position of the first set bit counted from the msb, 9 when the byte is zero
  function automatic logic [3:0] marker_pos(input logic [7:0] b);
    casez (b)
      8'b1???????: return 4'd1;
      8'b01??????: return 4'd2;
      8'b001?????: return 4'd3;
      8'b0001????: return 4'd4;
      8'b00001???: return 4'd5;
      8'b000001??: return 4'd6;
      8'b0000001?: return 4'd7;
      8'b00000001: return 4'd8;
      default:     return 4'd9;
    endcase
  endfunction

  task automatic clear_parse();
    hdr_phase = PH_IDLE;
    left_cnt  = '0;
    id_acc    = '0;
    size_acc  = '0;
    id_len    = '0;
    size_len  = '0;
  endtask

  // queue one result and go back to idle
  task automatic post_header(input status_t st, input logic [IdW-1:0] id,
                             input logic [IdLenW-1:0] idl, input logic [SizeW-1:0] sz,
                             input logic [SizeLenW-1:0] szl);
    result_t r;
    r.status       = st;
    r.element_id   = id;
    r.id_length    = idl;
    r.element_size = sz;
    r.size_length  = szl;
    expected_headers.push_back(r);
    clear_parse();
  endtask

  // the id survives a truncation only once all of its bytes are in
  task automatic post_truncated();
    logic id_done;
    id_done = (hdr_phase == PH_SZ_FIRST) || (hdr_phase == PH_SZ_REST);
    post_header(ST_TRUNCATED, id_done ? id_acc : '0, id_done ? id_len : '0, '0, '0);
  endtask

  // advance the parse by one header byte
  task automatic predict_byte(input logic [7:0] b, input logic eos);
    logic [3:0] len;
    len = marker_pos(b);
    case (hdr_phase)
      PH_IDLE: begin
        if (b[7:4] == 4'h0 || len > IdMaxBytes) begin
          post_header(ST_BAD_ID, '0, '0, '0, '0);
        end else begin
          id_acc    = IdW'(b);
          id_len    = len[IdLenW-1:0];
          left_cnt  = len - 4'd1;
          hdr_phase = (left_cnt != 4'd0) ? PH_ID_REST : PH_SZ_FIRST;
          if (eos) post_truncated();
        end
      end
      PH_ID_REST: begin
        id_acc = {id_acc[IdW-9:0], b};
        if (left_cnt != 4'd0) left_cnt = left_cnt - 4'd1;
        if (left_cnt == 4'd0) hdr_phase = PH_SZ_FIRST;
        if (eos) post_truncated();
      end
      PH_SZ_FIRST: begin
        if (b == 8'h00 || len > SizeMaxBytes) begin
          post_header(ST_BAD_SIZE, id_acc, id_len, '0, '0);
        end else begin
          // marker bit dropped from the first size byte
          size_acc = SizeW'(b & (8'hFF >> len));
          size_len = len;
          left_cnt = len - 4'd1;
          if (left_cnt == 4'd0) begin
            post_header(ST_OK, id_acc, id_len, size_acc, size_len);
          end else begin
            hdr_phase = PH_SZ_REST;
            if (eos) post_truncated();
          end
        end
      end
      default: begin
        size_acc = {size_acc[SizeW-9:0], b};
        if (left_cnt != 4'd0) left_cnt = left_cnt - 4'd1;
        if (left_cnt == 4'd0) begin
          post_header(ST_OK, id_acc, id_len, size_acc, size_len);
        end else if (eos) begin
          post_truncated();
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_parse();
      expected_headers.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        predict_byte(in_mon.data_byte, in_mon.end_of_stream);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_headers.size() == 0) begin
          $error("result with no header pending: status %0d id 0x%0h",
                 out_mon.status, out_mon.element_id);
          fail_count++;
        end else begin
          want = expected_headers.pop_front();
          check_field("status", want.status, out_mon.status);
          check_field("element_id", want.element_id, out_mon.element_id);
          check_field("id_length", want.id_length, out_mon.id_length);
          check_field("element_size", want.element_size, out_mon.element_size);
          check_field("size_length", want.size_length, out_mon.size_length);
        end
      end
    end
    headers_pending <= expected_headers.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ebml_hp_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned ItemsPerPhase = 350;
  localparam int unsigned LongStall     = 300;

  logic clk           = 1'b0;
  logic rst_n         = 1'b0;
  logic stall_request = 1'b0;
  int   fail_count;
  int   headers_pending;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   bytes_sent;
  int   cycle_cnt;

  // directed headers, {end_of_stream, data_byte}
  logic [8:0] directed_seq [27] = '{
    // one-byte id, one-byte size, all value bits set
    9'h0FF, 9'h0FF,
    // four-byte id, eight-byte unknown size
    9'h01A, 9'h045, 9'h0DF, 9'h0A3, 9'h001,
    9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
    // zero id byte at stream end, bad id wins
    9'h100,
    // zero size byte
    9'h042, 9'h086, 9'h000,
    // stream ends right after a complete id
    9'h181,
    // stream ends inside a three-byte id
    9'h023, 9'h183,
    // stream ends after the first of two size bytes
    9'h081, 9'h140,
    // zero size byte at stream end, bad size wins
    9'h081, 9'h100,
    // stream ends on the last header byte
    9'h081, 9'h181
  };

  ebml_hp_in_if  in_bus ();
  ebml_hp_out_if out_bus ();

  ebml_element_header_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  ebml_hp_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .fail_count     (fail_count),
    .headers_pending(headers_pending)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[ebml_element_header_parser] ERROR");
      $finish;
    end
  end

  // result receiver: random stalls plus one long hold-off
  initial begin : receiver
    int   stall_left;
    logic stall_served;
    stall_left    = 0;
    stall_served  = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (stall_request && !stall_served) begin
        stall_served = 1'b1;
        stall_left   = LongStall;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // one byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.data_byte     <= b;
    in_bus.end_of_stream <= eos;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // stop offering bytes until every owed result has come out
  task automatic wait_drain();
    in_bus.valid <= 1'b0;
    while (headers_pending != 0) @(negedge clk);
  endtask

  // mostly well-formed headers with random content, some truncated,
  // some with a zero size byte, some plain noise
  task automatic send_random_header();
    logic [7:0] hdr [12];
    logic [7:0] r8;
    logic       last_eos;
    int         kind;
    int         id_bytes;
    int         size_bytes;
    int         n;
    int         cut;
    kind = $urandom_range(99);
    if (kind >= 95) begin
      r8 = 8'($urandom_range(255));
      send_byte(r8, 1'($urandom_range(1)));
    end else begin
      id_bytes   = $urandom_range(1, 4);
      size_bytes = ($urandom_range(3) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
      r8         = 8'($urandom_range(255));
      hdr[0]     = (r8 | 8'h80) >> (id_bytes - 1);
      for (int k = 1; k < id_bytes; k++) hdr[k] = 8'($urandom_range(255));
      n = id_bytes;
      if (kind >= 90) begin
        hdr[n] = 8'h00;
        n++;
      end else begin
        r8     = 8'($urandom_range(255));
        hdr[n] = (r8 | 8'h80) >> (size_bytes - 1);
        for (int k = 1; k < size_bytes; k++) hdr[n + k] = 8'($urandom_range(255));
        n += size_bytes;
      end
      cut      = n - 1;
      last_eos = ($urandom_range(3) == 0);
      if (kind >= 80 && kind < 90) begin
        cut      = $urandom_range(n - 2);
        last_eos = 1'b1;
      end
      for (int k = 0; k <= cut; k++) send_byte(hdr[k], (k == cut) ? last_eos : 1'b0);
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    in_bus.valid         = 1'b0;
    in_bus.data_byte     = 8'h00;
    in_bus.end_of_stream = 1'b0;
    src_idle_pct         = 10;
    sink_idle_pct        = 48;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_seq[i]) send_byte(directed_seq[i][7:0], directed_seq[i][8]);
    while (bytes_sent < ItemsPerPhase) send_random_header();
    wait_drain();

    src_idle_pct  = 48;
    sink_idle_pct = 10;
    while (bytes_sent < 2 * ItemsPerPhase) send_random_header();
    wait_drain();

    // no idling; a burst of bad id bytes against a long receiver hold-off
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    stall_request = 1'b1;
    repeat (30) send_byte(8'($urandom_range(15)), 1'b0);
    while (bytes_sent < 3 * ItemsPerPhase) send_random_header();
    wait_drain();

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ebml_element_header_parser] OK");
    end else begin
      $display("[ebml_element_header_parser] ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ebml_hp_pkg.sv
hw/rtl/ebml_hp_in_if.sv
hw/rtl/ebml_hp_out_if.sv
hw/rtl/ebml_hp_core.sv
hw/rtl/ebml_element_header_parser.sv
test/ebml_hp_checker.sv
test/tb_top.sv
